// ----- rtl/core/cdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types for the circular deque: operation and status codes, and the
// control word that the front end hands to the back end.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int WordW = 32;

    typedef enum logic [1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_REAR  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_WRITE = 2'd1,
        ACC_READ  = 2'd2
    } t_access;

    typedef struct packed {
        t_access acc;
        t_status status;
        logic    now_empty;
        logic    now_full;
    } t_ctl;

endpackage

// ----- rtl/core/cdq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds until the next read.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/cdq_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cdq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_go;
    logic             rd_go;

    assign o_wr_ready = (r_cnt != CW'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign wr_go      = i_wr_valid && o_wr_ready;
    assign rd_go      = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_go) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (rd_go) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (wr_go && !rd_go) begin
            n_cnt = r_cnt + CW'(1);
        end else if (rd_go && !wr_go) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

// ----- rtl/core/cdq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_front
// Accepts operations, keeps the front and rear indices and the empty flag,
// and turns each item into at most one store access plus its final status.
// ----------------------------------------------------------------------------
module cdq_front #(
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_func,
    input  logic signed [31:0]  i_push_value,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output cdq_pkg::t_ctl       o_cmd_ctl,
    output logic [AW-1:0]       o_cmd_addr,
    output logic [31:0]         o_cmd_data
);

    import cdq_pkg::*;

    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_rear,  n_rear;
    logic          r_empty, n_empty;
    logic          accept;
    logic          full;
    t_func         func;
    t_ctl          ctl;
    logic [AW-1:0] addr;

    function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] x);
        return (x == AW'(DEPTH - 1)) ? '0 : x + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] x);
        return (x == '0) ? AW'(DEPTH - 1) : x - AW'(1);
    endfunction

    assign o_in_ready = i_cmd_ready;
    assign accept     = i_in_valid && i_cmd_ready;
    assign func       = t_func'(i_func);
    assign full       = !r_empty && (idx_next(r_rear) == r_front);

    always_comb begin
        n_front    = r_front;
        n_rear     = r_rear;
        n_empty    = r_empty;
        addr       = '0;
        ctl.acc    = ACC_NONE;
        ctl.status = ST_DONE;
        if (func inside {FUNC_PUSH_FRONT, FUNC_PUSH_REAR}) begin
            if (full) begin
                ctl.status = ST_FULL;
            end else if (r_empty) begin
                // First element always lands at entry zero.
                n_front = '0;
                n_rear  = '0;
                n_empty = 1'b0;
                addr    = '0;
                ctl.acc = ACC_WRITE;
            end else if (func == FUNC_PUSH_FRONT) begin
                n_front = idx_prev(r_front);
                addr    = n_front;
                ctl.acc = ACC_WRITE;
            end else begin
                n_rear  = idx_next(r_rear);
                addr    = n_rear;
                ctl.acc = ACC_WRITE;
            end
        end else begin
            if (r_empty) begin
                ctl.status = ST_EMPTY;
            end else begin
                addr    = (func == FUNC_POP_FRONT) ? r_front : r_rear;
                ctl.acc = ACC_READ;
                if (r_front == r_rear) begin
                    // Removing the last element returns both indices home.
                    n_front = '0;
                    n_rear  = '0;
                    n_empty = 1'b1;
                end else if (func == FUNC_POP_FRONT) begin
                    n_front = idx_next(r_front);
                end else begin
                    n_rear = idx_prev(r_rear);
                end
            end
        end
        ctl.now_empty = n_empty;
        ctl.now_full  = !n_empty && (idx_next(n_rear) == n_front);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
        end else if (accept) begin
            r_front <= n_front;
            r_rear  <= n_rear;
            r_empty <= n_empty;
        end
    end

    assign o_cmd_valid = accept;
    assign o_cmd_ctl   = ctl;
    assign o_cmd_addr  = addr;
    assign o_cmd_data  = i_push_value;

`ifndef NO_ASSERTIONS
    a_refused_no_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ctl.status != ST_DONE) |-> (ctl.acc == ACC_NONE))
        else $error("refused operation still touches the store");

    a_empty_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_front == '0 && r_rear == '0))
        else $error("empty deque with indices away from zero");

    a_full_refuses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && (func == FUNC_PUSH_FRONT || func == FUNC_PUSH_REAR))
        |=> ($stable(r_front) && $stable(r_rear) && !r_empty))
        else $error("push into full deque changed the indices");
`endif

endmodule

// ----- rtl/core/cdq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_back
// Carries out queued store accesses in order and forms the result items,
// with one access stage and one output register.
// ----------------------------------------------------------------------------
module cdq_back #(
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  cdq_pkg::t_ctl       i_cmd_ctl,
    input  logic [AW-1:0]       i_cmd_addr,
    input  logic [31:0]         i_cmd_data,
    output logic                o_ram_we,
    output logic [AW-1:0]       o_ram_waddr,
    output logic [31:0]         o_ram_wdata,
    output logic                o_ram_re,
    output logic [AW-1:0]       o_ram_raddr,
    input  logic [31:0]         i_ram_rdata,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_pop_value,
    output logic                o_now_empty,
    output logic                o_now_full
);

    import cdq_pkg::*;

    logic               r_s1_valid;
    t_ctl               r_s1_ctl;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic signed [31:0] r_pop_value;
    logic               r_now_empty;
    logic               r_now_full;
    logic               s1_adv;
    logic               s1_free;
    logic               take;

    assign s1_adv      = !r_out_valid || i_out_ready;
    assign s1_free     = !r_s1_valid || s1_adv;
    assign take        = i_cmd_valid && s1_free;
    assign o_cmd_ready = s1_free;

    assign o_ram_we    = take && (i_cmd_ctl.acc == ACC_WRITE);
    assign o_ram_waddr = i_cmd_addr;
    assign o_ram_wdata = i_cmd_data;
    assign o_ram_re    = take && (i_cmd_ctl.acc == ACC_READ);
    assign o_ram_raddr = i_cmd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_cmd_valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // The read data register only moves on a read, so it holds while the
    // access stage waits for the output register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_ctl <= i_cmd_ctl;
        end
        if (s1_adv && r_s1_valid) begin
            r_status    <= r_s1_ctl.status;
            r_pop_value <= (r_s1_ctl.acc == ACC_READ) ? i_ram_rdata : '0;
            r_now_empty <= r_s1_ctl.now_empty;
            r_now_full  <= r_s1_ctl.now_full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_pop_value = r_pop_value;
    assign o_now_empty = r_now_empty;
    assign o_now_full  = r_now_full;

`ifndef NO_ASSERTIONS
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram_we && o_ram_re))
        else $error("read and write issued together");

    a_take_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_s1_valid)
        else $error("taken command lost before the access stage");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv) |=> r_out_valid)
        else $error("access stage result lost before the output register");
`endif

endmodule

// ----- rtl/core/circular_double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// Deque of signed 32-bit words in a circular RAM, with front and rear push
// and pop, full and empty refusal, and flags after every operation.
// ----------------------------------------------------------------------------
// Path of an item: command queue, then store access, then output register.
// Throughput: one item per cycle while the receiver keeps i_out_ready high,
// set by the single store access per cycle.
// Reset clears the indices, the empty flag and all valid bits; the store is
// not cleared and needs no clearing pass, so items are taken right away.
module circular_double_ended_queue #(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_push_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_pop_value,
    output logic               o_now_empty,
    output logic               o_now_full
);

    import cdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $bits(t_ctl);
    localparam int QW = CW + AW + WordW;
    localparam int QueueDepth = 2;

    logic          f_valid;
    logic          f_ready;
    t_ctl          f_ctl;
    logic [AW-1:0] f_addr;
    logic [31:0]   f_data;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;
    logic          q_valid;
    logic          q_ready;
    t_ctl          q_ctl;
    logic [AW-1:0] q_addr;
    logic [31:0]   q_data;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    cdq_front #(.DEPTH(DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_push_value(i_push_value),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd_ctl   (f_ctl),
        .o_cmd_addr  (f_addr),
        .o_cmd_data  (f_data)
    );

    assign q_wdata = {f_ctl, f_addr, f_data};

    cdq_fifo #(.WIDTH(QW), .DEPTH(QueueDepth)) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_valid(f_valid),
        .o_wr_ready(f_ready),
        .i_wr_data (q_wdata),
        .o_rd_valid(q_valid),
        .i_rd_ready(q_ready),
        .o_rd_data (q_rdata)
    );

    assign q_ctl  = t_ctl'(q_rdata[QW-1 -: CW]);
    assign q_addr = q_rdata[WordW +: AW];
    assign q_data = q_rdata[WordW-1:0];

    cdq_back #(.DEPTH(DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd_ctl   (q_ctl),
        .i_cmd_addr  (q_addr),
        .i_cmd_data  (q_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_pop_value (o_pop_value),
        .o_now_empty (o_now_empty),
        .o_now_full  (o_now_full)
    );

    cdq_ram #(.WIDTH(WordW), .DEPTH(DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

endmodule

// ----- tb/sv/tb_circular_double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_double_ended_queue
// Self-checking bench for the circular deque. A mirror of the deque state
// predicts status, popped word and flags for every accepted item. The
// monitor compares each result with the oldest prediction. Stimulus is a
// directed prologue followed by fill, drain and mixed runs, under three
// patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_circular_double_ended_queue;

    import cdq_pkg::*;

    localparam int DEPTH = 128;
    localparam int IdxW  = $clog2(DEPTH);
    localparam int MaxReports = 10;

    typedef struct packed {
        t_func             func;
        logic signed [31:0] value;
    } t_deque_op;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] pop_value;
        logic               now_empty;
        logic               now_full;
    } t_deque_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_func              i_func = FUNC_PUSH_FRONT;
    logic signed [31:0] i_push_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_pop_value;
    logic               o_now_empty;
    logic               o_now_full;

    t_deque_op     ops_to_send[$];
    t_deque_result results_due[$];

    int send_idle_pct = 21;
    int recv_idle_pct = 63;
    int mismatches = 0;

    // Mirror of the deque contents and pointers.
    logic signed [31:0] mirror_store [DEPTH];
    logic [IdxW-1:0]    mirror_front = '0;
    logic [IdxW-1:0]    mirror_rear = '0;
    logic               mirror_empty = 1'b1;

    circular_double_ended_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_push_value(i_push_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_pop_value (o_pop_value),
        .o_now_empty (o_now_empty),
        .o_now_full  (o_now_full)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [IdxW-1:0] idx_after(logic [IdxW-1:0] i);
        return (int'(i) >= DEPTH - 1) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IdxW-1:0] idx_before(logic [IdxW-1:0] i);
        return (i == '0) ? IdxW'(DEPTH - 1) : i - 1'b1;
    endfunction

    function automatic logic mirror_full();
        return !mirror_empty && idx_after(mirror_rear) == mirror_front;
    endfunction

    // Applies one operation to the mirror and returns the result it causes.
    function automatic t_deque_result apply_deque_op(t_func f, logic signed [31:0] v);
        t_deque_result    r;
        logic [IdxW-1:0]  at;
        r.status    = ST_DONE;
        r.pop_value = '0;
        if (f == FUNC_PUSH_FRONT || f == FUNC_PUSH_REAR) begin
            if (mirror_full()) begin
                r.status = ST_FULL;
            end else if (mirror_empty) begin
                // The first element always lands in entry zero.
                mirror_front    = '0;
                mirror_rear     = '0;
                mirror_empty    = 1'b0;
                mirror_store[0] = v;
            end else if (f == FUNC_PUSH_FRONT) begin
                mirror_front               = idx_before(mirror_front);
                mirror_store[mirror_front] = v;
            end else begin
                mirror_rear               = idx_after(mirror_rear);
                mirror_store[mirror_rear] = v;
            end
        end else begin
            if (mirror_empty) begin
                r.status = ST_EMPTY;
            end else begin
                at          = (f == FUNC_POP_FRONT) ? mirror_front : mirror_rear;
                r.pop_value = mirror_store[at];
                if (mirror_front == mirror_rear) begin
                    mirror_front = '0;
                    mirror_rear  = '0;
                    mirror_empty = 1'b1;
                end else if (f == FUNC_POP_FRONT) begin
                    mirror_front = idx_after(mirror_front);
                end else begin
                    mirror_rear = idx_before(mirror_rear);
                end
            end
        end
        r.now_empty = mirror_empty;
        r.now_full  = mirror_full();
        return r;
    endfunction

    // Driver: presents queued items and records a prediction on acceptance.
    always @(posedge i_clk) begin : driver
        t_deque_op op;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                results_due.push_back(apply_deque_op(i_func, i_push_value));
            end
            if (i_in_valid && !o_in_ready) begin
                // Hold the item until it is taken.
            end else if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                op = ops_to_send.pop_front();
                i_func       <= op.func;
                i_push_value <= op.value;
                i_in_valid   <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks every accepted result against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_deque_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MaxReports) begin
                        $display("%0t: unexpected result status=%0d pop=%h empty=%b full=%b",
                                 $realtime, o_status, o_pop_value, o_now_empty, o_now_full);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (o_status !== want.status || o_pop_value !== want.pop_value ||
                        o_now_empty !== want.now_empty || o_now_full !== want.now_full) begin
                        mismatches++;
                        if (mismatches <= MaxReports) begin
                            $display("%0t: mismatch status %0d/%0d pop %h/%h empty %b/%b full %b/%b",
                                     $realtime, want.status, o_status, want.pop_value,
                                     o_pop_value, want.now_empty, o_now_empty,
                                     want.now_full, o_now_full);
                        end
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(t_func f, logic signed [31:0] v);
        t_deque_op op;
        op.func  = f;
        op.value = v;
        ops_to_send.push_back(op);
    endtask

    // Mostly runs that fill the deque until pushes bounce, or drain it until
    // pops bounce, with mixed and fully random runs in between.
    task automatic queue_random_ops(int count);
        int     sent;
        int     len;
        int     kind;
        t_func  f;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(9);
            if (kind <= 5) begin
                len = DEPTH + $urandom_range(12, 4);
            end else begin
                len = $urandom_range(60, 10);
            end
            for (int k = 0; k < len && sent < count; k++) begin
                if (kind <= 2) begin
                    f = $urandom_range(1) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT;
                end else if (kind <= 5) begin
                    f = $urandom_range(1) ? FUNC_POP_REAR : FUNC_POP_FRONT;
                end else begin
                    f = t_func'($urandom_range(3));
                end
                queue_op(f, (f == FUNC_POP_FRONT || f == FUNC_POP_REAR && kind == 9) ?
                            $urandom : pick_word());
                sent++;
            end
        end
    endtask

    task automatic wait_drained();
        while (ops_to_send.size() != 0 || i_in_valid || results_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Pops while empty, push while empty, pop of the last element,
        // front push wrapping below entry zero, and the word extremes.
        queue_op(FUNC_POP_FRONT, 32'sh1234_5678);
        queue_op(FUNC_POP_REAR, -32'sd1);
        queue_op(FUNC_PUSH_REAR, 32'sh8000_0000);
        queue_op(FUNC_POP_REAR, 32'sh0);
        queue_op(FUNC_PUSH_FRONT, 32'sh7fff_ffff);
        queue_op(FUNC_PUSH_FRONT, -32'sd1);
        queue_op(FUNC_PUSH_FRONT, 32'sh5555_5555);
        queue_op(FUNC_PUSH_REAR, 32'sh0);
        queue_op(FUNC_PUSH_REAR, 32'shaaaa_aaaa);
        queue_op(FUNC_POP_FRONT, 32'sh0);
        queue_op(FUNC_POP_REAR, 32'sh0);
        queue_op(FUNC_POP_FRONT, 32'sh0);
        queue_op(FUNC_POP_REAR, 32'sh0);
        queue_op(FUNC_POP_FRONT, 32'sh0);
        queue_op(FUNC_POP_FRONT, 32'sh0);
        queue_op(FUNC_POP_REAR, 32'sh0);
        queue_op(FUNC_PUSH_FRONT, 32'sh8000_0001);
        queue_op(FUNC_POP_FRONT, 32'sh0);
        queue_op(FUNC_PUSH_REAR, 32'sh7fff_fffe);
        queue_op(FUNC_POP_FRONT, 32'sh0);
        queue_random_ops(360);
        // The sender holds off here until every predicted result has come.
        wait_drained();

        send_idle_pct = 63;
        recv_idle_pct = 21;
        queue_random_ops(380);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_ops(380);
        wait_drained();

        repeat (8) @(negedge i_clk);
        if (results_due.size() != 0 || mismatches != 0) begin
            $display("*** FAILED ***");
        end else begin
            $display("*** PASSED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
